>>> sv/nat_header_translation_core_assert.svh
// Assertion macros used by the translation core checker.
`ifndef NAT_HEADER_TRANSLATION_CORE_ASSERT_SVH
`define NAT_HEADER_TRANSLATION_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NHTC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NHTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/nhtc_pkg.sv
// Types, constants and register codes of the header translation core.
`timescale 1ns / 1ps

package nhtc_pkg;

    localparam int ADDR_W     = 32;
    localparam int PORT_W     = 16;
    localparam int OCTET_W    = 8;
    localparam int PREFIX_W   = 16;
    localparam int DIR_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int TABLE_ENTRIES_DEF = 256;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_PRIVATE_PREFIX   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PUBLIC_ADDRESS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PORT_BASE        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WAN_SOURCE_OCTET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WAN_DEST_OCTET   = 3'd4;

    // Register reset values
    localparam logic [PREFIX_W-1:0] PRIVATE_PREFIX_RST   = 16'hAC10;
    localparam logic [ADDR_W-1:0]   PUBLIC_ADDRESS_RST   = 32'h0A00_0001;
    localparam logic [PORT_W-1:0]   PORT_BASE_RST        = 16'd1024;
    localparam logic [OCTET_W-1:0]  WAN_SOURCE_OCTET_RST = 8'd10;
    localparam logic [OCTET_W-1:0]  WAN_DEST_OCTET_RST   = 8'd0;

    // Last octet that is never translated outbound
    localparam logic [OCTET_W-1:0] NO_XLATE_OCTET = 8'd255;

    // Direction codes
    localparam logic [DIR_W-1:0] DIR_NONE    = 2'd0;
    localparam logic [DIR_W-1:0] DIR_LAN_WAN = 2'd1;
    localparam logic [DIR_W-1:0] DIR_WAN_LAN = 2'd2;

    typedef struct packed {
        logic [PREFIX_W-1:0] private_prefix;
        logic [ADDR_W-1:0]   public_address;
        logic [PORT_W-1:0]   port_base;
        logic [OCTET_W-1:0]  wan_source_octet;
        logic [OCTET_W-1:0]  wan_dest_octet;
    } cfg_t;

    typedef struct packed {
        logic [ADDR_W-1:0] in_src_addr;
        logic [ADDR_W-1:0] in_dst_addr;
        logic [PORT_W-1:0] in_src_port;
        logic [PORT_W-1:0] in_dst_port;
    } in_hdr_t;

    typedef struct packed {
        logic [ADDR_W-1:0] out_src_addr;
        logic [ADDR_W-1:0] out_dst_addr;
        logic [PORT_W-1:0] out_src_port;
        logic [PORT_W-1:0] out_dst_port;
        logic [DIR_W-1:0]  direction;
    } out_hdr_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [PORT_W-1:0] port;
    } bind_entry_t;

    // Table access request: at most one of the two per cycle
    typedef struct packed {
        logic wr;
        logic rd;
    } bind_req_t;

endpackage

>>> sv/nhtc_stream_if.sv
// Valid/ready stream channel carrying one header per transfer.
`timescale 1ns / 1ps

interface nhtc_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

>>> sv/nhtc_cfg_regs.sv
// Configuration register bank of the translation core.
`timescale 1ns / 1ps

module nhtc_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [nhtc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [nhtc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output nhtc_pkg::cfg_t                     cfg
);

    nhtc_pkg::cfg_t cfg_reg;
    nhtc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                nhtc_pkg::REG_PRIVATE_PREFIX:
                    cfg_next.private_prefix = cfg_wdata[nhtc_pkg::PREFIX_W-1:0];
                nhtc_pkg::REG_PUBLIC_ADDRESS:
                    cfg_next.public_address = cfg_wdata[nhtc_pkg::ADDR_W-1:0];
                nhtc_pkg::REG_PORT_BASE:
                    cfg_next.port_base = cfg_wdata[nhtc_pkg::PORT_W-1:0];
                nhtc_pkg::REG_WAN_SOURCE_OCTET:
                    cfg_next.wan_source_octet = cfg_wdata[nhtc_pkg::OCTET_W-1:0];
                nhtc_pkg::REG_WAN_DEST_OCTET:
                    cfg_next.wan_dest_octet = cfg_wdata[nhtc_pkg::OCTET_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.private_prefix   <= nhtc_pkg::PRIVATE_PREFIX_RST;
            cfg_reg.public_address   <= nhtc_pkg::PUBLIC_ADDRESS_RST;
            cfg_reg.port_base        <= nhtc_pkg::PORT_BASE_RST;
            cfg_reg.wan_source_octet <= nhtc_pkg::WAN_SOURCE_OCTET_RST;
            cfg_reg.wan_dest_octet   <= nhtc_pkg::WAN_DEST_OCTET_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> sv/nhtc_bind_table.sv
// Binding table: single-port synchronous memory with per-entry valid bits.
`timescale 1ns / 1ps

module nhtc_bind_table #(
    parameter int ENTRIES = nhtc_pkg::TABLE_ENTRIES_DEF,
    parameter int IDX_W   = $clog2(ENTRIES)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  nhtc_pkg::bind_req_t   req,
    input  logic [IDX_W-1:0]      idx,
    input  nhtc_pkg::bind_entry_t wr_entry,
    output nhtc_pkg::bind_entry_t rd_entry
);

    nhtc_pkg::bind_entry_t mem [ENTRIES];
    logic [ENTRIES-1:0]    valid_reg;
    nhtc_pkg::bind_entry_t rd_data_reg;
    logic                  rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr)
        begin
            mem[idx] <= wr_entry;
        end
        if (req.rd)
        begin
            rd_data_reg <= mem[idx];
        end
    end

    // Entries never written since reset read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr)
            begin
                valid_reg[idx] <= 1'b1;
            end
            if (req.rd)
            begin
                rd_valid_reg <= valid_reg[idx];
            end
        end
    end

    assign rd_entry = rd_valid_reg ? rd_data_reg : '0;

endmodule

>>> sv/nat_header_translation_core.sv
// Top level of the IPv4/TCP header address and port translation core.
`timescale 1ns / 1ps

// Accepts one header per cycle while the output is not stalled and returns it
// translated through the input stage, then the output register. The binding
// table has a single memory port: each header makes at most one access, a write
// for an outbound header or a read for an inbound one, issued at the cycle
// the header is taken. The table reads as all zero right after reset through
// per-entry valid bits, so no clearing pass is needed and the block is ready
// as soon as reset is released. Stalls on the output hold both stages.
module nat_header_translation_core #(
    parameter int TABLE_ENTRIES = nhtc_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [nhtc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nhtc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    nhtc_stream_if.sink                     hdr_in,
    nhtc_stream_if.source                   hdr_out
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [nhtc_pkg::OCTET_W:0] ENTRY_LIMIT = (nhtc_pkg::OCTET_W + 1)'(TABLE_ENTRIES);

    nhtc_pkg::cfg_t        cfg;
    nhtc_pkg::in_hdr_t     in_hdr;
    nhtc_pkg::bind_req_t   tbl_req;
    logic [IDX_W-1:0]      tbl_idx;
    nhtc_pkg::bind_entry_t tbl_wr_entry;
    nhtc_pkg::bind_entry_t tbl_rd_entry;

    logic                         accept;
    logic                         s1_adv;
    logic                         is_out;
    logic                         is_in;
    logic                         do_store;
    logic                         do_fetch;
    logic [nhtc_pkg::OCTET_W-1:0] src_octet;
    logic [nhtc_pkg::OCTET_W-1:0] dst_octet;

    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    logic                       s1_fetch_reg;
    nhtc_pkg::out_hdr_t         s1_hdr_reg;
    nhtc_pkg::out_hdr_t         s1_hdr_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    nhtc_pkg::out_hdr_t         out_hdr_reg;
    nhtc_pkg::out_hdr_t         out_hdr_next;
    logic [nhtc_pkg::DIR_W-1:0] held_dir_reg;
    logic [nhtc_pkg::DIR_W-1:0] held_dir_next;

    nhtc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    assign in_hdr    = hdr_in.data;
    assign src_octet = in_hdr.in_src_addr[nhtc_pkg::OCTET_W-1:0];
    assign dst_octet = in_hdr.in_dst_addr[nhtc_pkg::OCTET_W-1:0];

    // Both tests look at the header as it arrives; outbound wins
    assign is_out = (in_hdr.in_src_addr[nhtc_pkg::ADDR_W-1 -: nhtc_pkg::PREFIX_W]
                     == cfg.private_prefix);
    assign is_in  = !is_out
                    && (in_hdr.in_src_addr[nhtc_pkg::ADDR_W-1 -: nhtc_pkg::OCTET_W]
                        == cfg.wan_source_octet)
                    && (in_hdr.in_dst_addr[nhtc_pkg::ADDR_W-1 -: nhtc_pkg::OCTET_W]
                        == cfg.wan_dest_octet);

    assign do_store = is_out && (src_octet != nhtc_pkg::NO_XLATE_OCTET)
                      && ({1'b0, src_octet} < ENTRY_LIMIT);
    assign do_fetch = is_in && ({1'b0, dst_octet} < ENTRY_LIMIT);

    assign s1_adv       = !out_valid_reg || hdr_out.ready;
    assign hdr_in.ready = !s1_valid_reg || s1_adv;
    assign accept       = hdr_in.valid && hdr_in.ready;

    assign tbl_req.wr   = accept && do_store;
    assign tbl_req.rd   = accept && do_fetch;
    assign tbl_idx      = do_store ? src_octet[IDX_W-1:0] : dst_octet[IDX_W-1:0];
    assign tbl_wr_entry = '{addr: in_hdr.in_src_addr, port: in_hdr.in_src_port};

    nhtc_bind_table #(
        .ENTRIES (TABLE_ENTRIES),
        .IDX_W   (IDX_W)
    ) u_bind_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (tbl_req),
        .idx      (tbl_idx),
        .wr_entry (tbl_wr_entry),
        .rd_entry (tbl_rd_entry)
    );

    always_comb
    begin
        priority if (is_out)
        begin
            held_dir_next = nhtc_pkg::DIR_LAN_WAN;
        end
        else if (is_in)
        begin
            held_dir_next = nhtc_pkg::DIR_WAN_LAN;
        end
        else
        begin
            held_dir_next = held_dir_reg;
        end

        s1_hdr_next.out_src_addr = in_hdr.in_src_addr;
        s1_hdr_next.out_dst_addr = in_hdr.in_dst_addr;
        s1_hdr_next.out_src_port = in_hdr.in_src_port;
        s1_hdr_next.out_dst_port = in_hdr.in_dst_port;
        s1_hdr_next.direction    = held_dir_next;
        if (do_store)
        begin
            s1_hdr_next.out_src_addr = cfg.public_address;
            s1_hdr_next.out_src_port = cfg.port_base + nhtc_pkg::PORT_W'(src_octet);
        end

        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        // Merge the table read into the destination on the way out
        out_valid_next = out_valid_reg;
        out_hdr_next   = out_hdr_reg;
        if (s1_adv)
        begin
            out_valid_next = s1_valid_reg;
            out_hdr_next   = s1_hdr_reg;
            if (s1_fetch_reg)
            begin
                out_hdr_next.out_dst_addr = tbl_rd_entry.addr;
                out_hdr_next.out_dst_port = tbl_rd_entry.port;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            held_dir_reg  <= nhtc_pkg::DIR_NONE;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                held_dir_reg <= held_dir_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_hdr_reg   <= s1_hdr_next;
            s1_fetch_reg <= do_fetch;
        end
        out_hdr_reg <= out_hdr_next;
    end

    assign hdr_out.valid = out_valid_reg;
    assign hdr_out.data  = out_hdr_reg;

endmodule

>>> sv/nhtc_checker.sv
// Port-level checker for the translation core, bound to the top level.
`timescale 1ns / 1ps

`include "nat_header_translation_core_assert.svh"

module nhtc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input nhtc_pkg::out_hdr_t out_data
);

    logic in_xfer;

    assign in_xfer = in_valid && in_ready;

    `NHTC_ASSERT_NEXT(a_out_valid_held, clk, rst_n, out_valid && !out_ready, out_valid, "output valid dropped while stalled")
    `NHTC_ASSERT_NEXT(a_out_data_held, clk, rst_n, out_valid && !out_ready, $stable(out_data), "output header changed while stalled")
    `NHTC_ASSERT_IMPLY(a_no_stray_result, clk, rst_n, $rose(out_valid), $past(in_xfer, 2), "result without an input transfer two cycles earlier")
    `NHTC_ASSERT_IMPLY(a_backpressure_only, clk, rst_n, !in_ready, out_valid && !out_ready, "input stalled while output is free")

endmodule

bind nat_header_translation_core nhtc_checker u_nhtc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (hdr_in.valid),
    .in_ready  (hdr_in.ready),
    .out_valid (hdr_out.valid),
    .out_ready (hdr_out.ready),
    .out_data  (hdr_out.data)
);
